/* rtl/core/bds_pkg.sv */
// Shared types and constants of the baud divisor search block.
`default_nettype none
package bds_pkg;

  // Divider operand width: the rounding numerator stays below 2^35.
  localparam int unsigned DivW = 35;
  localparam int unsigned CntW = $clog2(DivW);

  localparam int unsigned ClockW = 27;
  localparam int unsigned BaudW  = 24;
  localparam int unsigned RateW  = 25;
  localparam int unsigned SelW   = 2;
  localparam int unsigned BrvW   = 8;
  localparam int unsigned DivValW = 9;   // divisor 1..256
  localparam int unsigned ShiftW  = 4;   // rate factor shift up to 11

  localparam logic [ClockW-1:0] ClockReset = ClockW'(50000000);
  localparam logic [DivValW-1:0] DivMax    = DivValW'(256);
  localparam logic [ShiftW-1:0] AsyncShift = ShiftW'(5);  // factor 32
  localparam logic [ShiftW-1:0] SyncShift  = ShiftW'(2);  // factor 4
  localparam logic [SelW-1:0]   SelLast    = SelW'(3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_WAIT1,
    ST_DIV2,
    ST_WAIT2,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

/* rtl/core/baud_divisor_search.sv */
// Top level of the baud divisor search: sequencer, best-setting tracking, ports.
`default_nettype none
// Finds a serial-port prescaler selection and divisor for a requested bit rate.
// A word on the slave side carries the rate (tdata) and the mode (tuser: 0 async,
// 1 clocked sync). Selections 0..3 are tried in order with rate factor 32*4^n
// (async) or 4*4^n (sync); each yields a rounded divisor, kept when it lies in
// 1..256, and the achieved rate clock_hz / (factor * divisor). The first setting
// with the strictly smallest rate error wins, and the search ends once that error
// is at most one percent of the request. A zero rate or no usable divisor gives
// status 1 with all other fields zero. Both divisions per selection run on one
// shared restoring divider at one bit per cycle, so a word takes up to eight
// divisions in the worst case; the block accepts no new word while a search runs.
// A finished result waits in an output register, so the next word may enter
// before it is taken. clock_hz must be written over the cfg channel only while
// the block is idle; the block itself does not enforce this.
module baud_divisor_search import bds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: clock_hz
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [26:0] cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] req_rate
  input  logic [0:0]  s_axis_tuser,   // [0] sync_mode
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [1:0] clock_select, [9:2] bit_rate_value,
                                      // [34:10] achieved_rate, [39:35] zero
  output logic [0:0]  m_axis_tuser    // [0] status
);

  state_e state_q, state_d;

  logic [ClockW-1:0]  clock_hz_q;
  logic [BaudW-1:0]   baud_q, baud_d;
  logic               sync_q, sync_d;
  logic [SelW-1:0]    sel_q, sel_d;
  logic [DivValW-1:0] div_q, div_d;
  logic               found_q, found_d;
  logic [SelW-1:0]    best_sel_q, best_sel_d;
  logic [DivValW-1:0] best_div_q, best_div_d;
  logic [ClockW-1:0]  best_rate_q, best_rate_d;
  logic [ClockW-1:0]  best_err_q, best_err_d;

  logic               m_valid_q, m_valid_d;
  logic [39:0]        m_data_q, m_data_d;
  logic               m_user_q, m_user_d;

  logic [ShiftW-1:0]  shift;
  logic [DivW-1:0]    den;
  logic [DivW-1:0]    numer;
  logic [DivW-1:0]    fac_div;
  logic [ClockW-1:0]  rate;
  logic [ClockW-1:0]  err;
  logic [33:0]        err_x100;
  logic               div_ok;
  logic               better;
  logic               in_accept;
  logic               out_free;
  logic [BrvW-1:0]    brv;

  div_req_t div_req;
  div_rsp_t div_rsp;

  bds_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Rate factor is a power of two: multiply by shifting.
  assign shift   = (sync_q ? SyncShift : AsyncShift) + ShiftW'({sel_q, 1'b0});
  assign den     = DivW'(baud_q) << shift;
  assign numer   = DivW'(clock_hz_q) + (den >> 1);
  assign fac_div = DivW'(div_q) << shift;

  assign div_req.start    = (state_q == ST_DIV1) || (state_q == ST_DIV2);
  assign div_req.dividend = (state_q == ST_DIV1) ? numer : DivW'(clock_hz_q);
  assign div_req.divisor  = (state_q == ST_DIV1) ? den : fac_div;

  // Divisor from the first division is usable only within 1..256.
  assign div_ok = (div_rsp.quotient != '0) && (div_rsp.quotient <= DivW'(DivMax));

  // Achieved rate and its distance from the request.
  assign rate = div_rsp.quotient[ClockW-1:0];
  assign err  = (rate > ClockW'(baud_q)) ? (rate - ClockW'(baud_q))
                                         : (ClockW'(baud_q) - rate);
  // err <= floor(baud/100) is the same as 100*err <= baud
  assign err_x100 = (34'(err) << 6) + (34'(err) << 5) + (34'(err) << 2);
  assign better   = !found_q || (err < best_err_q);

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_valid_q || m_axis_tready;
  assign brv       = BrvW'(best_div_q - DivValW'(1));

  always_comb begin
    state_d     = state_q;
    baud_d      = baud_q;
    sync_d      = sync_q;
    sel_d       = sel_q;
    div_d       = div_q;
    found_d     = found_q;
    best_sel_d  = best_sel_q;
    best_div_d  = best_div_q;
    best_rate_d = best_rate_q;
    best_err_d  = best_err_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_data_d    = m_data_q;
    m_user_d    = m_user_q;
    s_axis_tready = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          baud_d  = s_axis_tdata;
          sync_d  = s_axis_tuser[0];
          sel_d   = '0;
          found_d = 1'b0;
          // zero rate: skip the search, report the error result
          state_d = (s_axis_tdata == '0) ? ST_FINISH : ST_DIV1;
        end
      end
      ST_DIV1: state_d = ST_WAIT1;
      ST_WAIT1: begin
        if (div_rsp.done) begin
          div_d = div_rsp.quotient[DivValW-1:0];
          if (div_ok) begin
            state_d = ST_DIV2;
          end else if (sel_q == SelLast) begin
            state_d = ST_FINISH;
          end else begin
            sel_d   = sel_q + SelW'(1);
            state_d = ST_DIV1;
          end
        end
      end
      ST_DIV2: state_d = ST_WAIT2;
      ST_WAIT2: begin
        if (div_rsp.done) begin
          if (better) begin
            found_d     = 1'b1;
            best_sel_d  = sel_q;
            best_div_d  = div_q;
            best_rate_d = rate;
            best_err_d  = err;
          end
          if ((better && (err_x100 <= 34'(baud_q))) || (sel_q == SelLast)) begin
            state_d = ST_FINISH;
          end else begin
            sel_d   = sel_q + SelW'(1);
            state_d = ST_DIV1;
          end
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (out_free) begin
          m_valid_d = 1'b1;
          if (found_q) begin
            m_data_d = {5'd0, best_rate_q[RateW-1:0], brv, best_sel_q};
            m_user_d = 1'b0;
          end else begin
            m_data_d = '0;
            m_user_d = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_valid_q  <= 1'b0;
      clock_hz_q <= ClockReset;
      found_q    <= 1'b0;
      sel_q      <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      found_q   <= found_d;
      sel_q     <= sel_d;
      if (cfg_valid_i) begin
        clock_hz_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    baud_q      <= baud_d;
    sync_q      <= sync_d;
    div_q       <= div_d;
    best_sel_q  <= best_sel_d;
    best_div_q  <= best_div_d;
    best_rate_q <= best_rate_d;
    best_err_q  <= best_err_d;
    m_data_q    <= m_data_d;
    m_user_q    <= m_user_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
`default_nettype wire

/* rtl/core/bds_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module bds_divider import bds_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [DivW-1:0] dsr_q, dsr_d;
  logic [DivW:0]   trial;
  logic [DivW:0]   diff;
  logic            ge;

  assign trial = {rem_q, quo_q[DivW-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the low bits hold it
      rem_d = ge ? diff[DivW-1:0] : trial[DivW-1:0];
      quo_d = {quo_q[DivW-2:0], ge};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire

/* rtl/core/bds_checker.sv */
// Port-level assertions for the baud divisor search, bound to the top level.
`default_nettype none
module bds_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // Stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Error result carries all-zero fields.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 40'd0)
    else $error("error result with nonzero fields");

  // Ready drops once a word is taken: the block leaves idle to run the search.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after accept");

  // A new result appears only at the end of a search.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while idle");

endmodule

bind baud_divisor_search bds_checker u_bds_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
